// ----- rtl/core/bsa_pkg.sv -----
// Package with shared codes, widths and controller/datapath interface types.
package bsa_pkg;

  localparam int DIV_W = 32;
  localparam int SZ_W  = 17;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_GET   = 2'd2;
  localparam logic [1:0] REQ_BAD   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] CFG_ITEM_SIZE  = 2'd0;
  localparam logic [1:0] CFG_ITEM_ALIGN = 2'd1;
  localparam logic [1:0] CFG_ITEM_COUNT = 2'd2;
  localparam logic [1:0] CFG_DATA_BASE  = 2'd3;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_INVALID,
    RES_ADDR,
    RES_FREED
  } res_kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SIZE_WAIT,
    S_SIZE_MUL,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_GET_RD,
    S_GET_CHK,
    S_FREE_WAIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic      cap;
    logic      div_start;
    logic      div_free;
    logic      sz_load;
    logic      idx_clr;
    logic      idx_inc;
    logic      idx_ld_sidx;
    logic      idx_ld_quo;
    logic      mem_rd;
    logic      mem_wr;
    logic      mem_wdata;
    logic      mul;
    logic      res_set;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       sz_valid;
    logic       div_done;
    logic       rd_bit;
    logic       idx_at_n;
    logic       clr_last;
    logic       sidx_ok;
    logic       free_ok;
    logic       out_busy;
  } sts_t;

endpackage

// ----- rtl/core/bitmap_slab_allocator_unit.sv -----
// Top level of the bitmap slab allocator, joining controller and datapath.
// One request is handled at a time; a new request is taken while the previous result still
// waits at the output. After reset a clearing pass zeroes every slot of the bitmap memory
// before the first request is taken. A get reads the bit of the given slot; an allocate
// scans the bitmap from slot 0, reading and checking each slot in turn, until it finds and
// marks the first free one; bitmap read data is registered. A free runs the iterative
// divider to split the offset into index and remainder, then reads the bit and clears it if
// set. The first request after a write to the size or alignment register, before it is
// handled, computes the rounded slot size on the same divider.
module bitmap_slab_allocator_unit
  import bsa_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_slot_address,
  output logic [5:0]  out_granted_index
);

  cmd_t cmd;
  sts_t sts;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_req_type),
    .in_address        (in_address),
    .in_slot_index     (in_slot_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot_address  (out_slot_address),
    .out_granted_index (out_granted_index)
  );

endmodule

// ----- rtl/core/bsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/core/bsa_divider.sv -----
// Restoring divider producing one quotient bit per cycle.
module bsa_divider
  import bsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [SZ_W-1:0]  divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [SZ_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r;
  logic [SZ_W-1:0]  rem_r;
  logic [SZ_W-1:0]  dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SZ_W:0]    rem_sh;
  logic             take;

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign take   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(DIV_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], take};
      rem_r <= take ? SZ_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[SZ_W-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/core/bsa_datapath.sv -----
// Datapath with configuration, slot size, bitmap memory, address arithmetic and output.
module bsa_datapath
  import bsa_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_slot_index,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_slot_address,
  output logic [5:0]  out_granted_index
);

  localparam int IW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int NW = CW > 7 ? CW : 7;
  localparam int PW = SZ_W + CW;

  logic [15:0] item_size_r;
  logic [8:0]  item_align_r;
  logic [6:0]  item_count_r;
  logic [31:0] data_base_r;

  logic [1:0]  req_r;
  logic [31:0] addr_r;
  logic [5:0]  sidx_r;

  logic [SZ_W-1:0] sz_r;
  logic            sz_valid_r;
  logic [CW-1:0]   idx_r;
  logic [CW-1:0]   idx_nxt;
  logic [PW-1:0]   prod_r;

  logic [1:0]  pend_status_r;
  logic [31:0] pend_addr_r;
  logic [5:0]  pend_idx_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [1:0]  out_status_r;
  logic [31:0] out_addr_r;
  logic [5:0]  out_idx_r;

  logic [15:0]      size_fix;
  logic [8:0]       align_fix;
  logic [NW-1:0]    n_w;
  logic [DIV_W-1:0] div_dividend;
  logic [SZ_W-1:0]  div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [SZ_W-1:0]  div_rem;
  logic             rd_bit;
  logic [SZ_W+8:0]  size_prod;

  assign size_fix  = (item_size_r == '0) ? 16'd1 : item_size_r;
  assign align_fix = (item_align_r == '0) ? 9'd1 : item_align_r;
  assign n_w = (NW'(item_count_r) > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(item_count_r);

  assign div_dividend = cmd.div_free ? (addr_r - data_base_r)
                                     : (DIV_W'(size_fix) + DIV_W'(align_fix) - 1'b1);
  assign div_divisor  = cmd.div_free ? sz_r : SZ_W'(align_fix);
  assign size_prod    = div_quo[SZ_W-1:0] * align_fix;

  bsa_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  bsa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_bitmap (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .waddr (idx_r[IW-1:0]),
    .wdata (cmd.mem_wdata),
    .re    (cmd.mem_rd),
    .raddr (idx_r[IW-1:0]),
    .rdata (rd_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_size_r  <= 16'd4;
      item_align_r <= 9'd4;
      item_count_r <= 7'd64;
      data_base_r  <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ITEM_SIZE:  item_size_r  <= cfg_wdata[15:0];
        CFG_ITEM_ALIGN: item_align_r <= cfg_wdata[8:0];
        CFG_ITEM_COUNT: item_count_r <= cfg_wdata[6:0];
        CFG_DATA_BASE:  data_base_r  <= cfg_wdata;
        default:        item_size_r  <= item_size_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sz_valid_r <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_ITEM_SIZE || cfg_index == CFG_ITEM_ALIGN)) begin
      sz_valid_r <= 1'b0;
    end else if (cmd.sz_load) begin
      sz_valid_r <= 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end else if (cmd.idx_ld_sidx) begin
      idx_nxt = CW'(sidx_r);
    end else if (cmd.idx_ld_quo) begin
      idx_nxt = div_quo[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r  <= in_req_type;
      addr_r <= in_address;
      sidx_r <= in_slot_index;
    end
    if (cmd.sz_load) begin
      sz_r <= size_prod[SZ_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= sz_r * idx_r;
    end
    if (cmd.res_set) begin
      case (cmd.res_kind)
        RES_ADDR: begin
          pend_status_r <= ST_OK;
          pend_addr_r   <= data_base_r + 32'(prod_r);
          pend_idx_r    <= 6'(idx_r);
        end
        RES_FREED: begin
          pend_status_r <= ST_OK;
          pend_addr_r   <= addr_r;
          pend_idx_r    <= 6'(idx_r);
        end
        RES_INVALID: begin
          pend_status_r <= ST_INVALID;
          pend_addr_r   <= '0;
          pend_idx_r    <= '0;
        end
        default: begin
          pend_status_r <= ST_NONE;
          pend_addr_r   <= '0;
          pend_idx_r    <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= pend_status_r;
      out_addr_r   <= pend_addr_r;
      out_idx_r    <= pend_idx_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    sts.req      = req_r;
    sts.sz_valid = sz_valid_r;
    sts.div_done = div_done;
    sts.rd_bit   = rd_bit;
    sts.idx_at_n = NW'(idx_r) >= n_w;
    sts.clr_last = idx_r == CW'(MAX_SLOTS - 1);
    sts.sidx_ok  = NW'(sidx_r) < n_w;
    sts.free_ok  = (div_rem == '0) && (div_quo < DIV_W'(n_w));
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_address  = out_addr_r;
  assign out_granted_index = out_idx_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("Result register overwritten before it was taken.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_addr_r == '0 && out_idx_r == '0))
    else $error("Failed request carries a non-zero address or index.");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("Divider started while busy.");

  a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_wr && !cmd.mem_wdata && cmd.res_set) |-> !sts.idx_at_n)
    else $error("Slot released outside the active range.");

endmodule

// ----- rtl/core/bsa_ctrl.sv -----
// Controller state machine sequencing each request through the datapath.
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:     if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:      if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (!sts.sz_valid) begin
          state_nxt = S_SIZE_WAIT;
        end else begin
          case (sts.req)
            REQ_ALLOC: state_nxt = S_SCAN_RD;
            REQ_FREE:  state_nxt = S_FREE_WAIT;
            REQ_GET:   state_nxt = sts.sidx_ok ? S_GET_RD : S_DONE;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SIZE_WAIT: if (sts.div_done) state_nxt = S_SIZE_MUL;
      S_SIZE_MUL:  state_nxt = S_DISPATCH;
      S_SCAN_RD:   state_nxt = sts.idx_at_n ? S_DONE : S_SCAN_CHK;
      S_SCAN_CHK:  state_nxt = sts.rd_bit ? S_SCAN_RD : S_MUL;
      S_GET_RD:    state_nxt = S_GET_CHK;
      S_GET_CHK:   state_nxt = sts.rd_bit ? S_MUL : S_DONE;
      S_FREE_WAIT: begin
        if (sts.div_done) state_nxt = sts.free_ok ? S_FREE_RD : S_DONE;
      end
      S_FREE_RD:   state_nxt = S_FREE_CHK;
      S_FREE_CHK:  state_nxt = S_DONE;
      S_MUL:       state_nxt = S_ADD;
      S_ADD:       state_nxt = S_DONE;
      S_DONE:      if (!sts.out_busy) state_nxt = S_IDLE;
      default:     state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.mem_wr    = 1'b1;
        cmd.mem_wdata = 1'b0;
        cmd.idx_inc   = !sts.clr_last;
        cmd.idx_clr   = sts.clr_last;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      S_DISPATCH: begin
        if (!sts.sz_valid) begin
          cmd.div_start = 1'b1;
        end else begin
          case (sts.req)
            REQ_ALLOC: cmd.idx_clr = 1'b1;
            REQ_FREE: begin
              cmd.div_start = 1'b1;
              cmd.div_free  = 1'b1;
            end
            REQ_GET: begin
              cmd.idx_ld_sidx = sts.sidx_ok;
              cmd.res_set     = !sts.sidx_ok;
              cmd.res_kind    = RES_NONE;
            end
            default: begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = RES_INVALID;
            end
          endcase
        end
      end
      S_SIZE_MUL: cmd.sz_load = 1'b1;
      S_SCAN_RD: begin
        cmd.mem_rd   = !sts.idx_at_n;
        cmd.res_set  = sts.idx_at_n;
        cmd.res_kind = RES_NONE;
      end
      S_SCAN_CHK: begin
        cmd.idx_inc   = sts.rd_bit;
        cmd.mem_wr    = !sts.rd_bit;
        cmd.mem_wdata = 1'b1;
      end
      S_GET_RD: cmd.mem_rd = 1'b1;
      S_GET_CHK: begin
        cmd.res_set  = !sts.rd_bit;
        cmd.res_kind = RES_NONE;
      end
      S_FREE_WAIT: begin
        cmd.div_free   = 1'b1;
        cmd.idx_ld_quo = sts.div_done && sts.free_ok;
        cmd.res_set    = sts.div_done && !sts.free_ok;
        cmd.res_kind   = RES_INVALID;
      end
      S_FREE_RD: cmd.mem_rd = 1'b1;
      S_FREE_CHK: begin
        cmd.mem_wr    = sts.rd_bit;
        cmd.mem_wdata = 1'b0;
        cmd.res_set   = 1'b1;
        cmd.res_kind  = sts.rd_bit ? RES_FREED : RES_INVALID;
      end
      S_MUL: cmd.mul = 1'b1;
      S_ADD: begin
        cmd.res_set  = 1'b1;
        cmd.res_kind = RES_ADDR;
      end
      S_DONE: cmd.out_load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_ready && !cmd.out_load))
    else $error("Request taken during the clearing pass.");

  a_size_first: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_rd && state_r != S_CLEAR) |-> sts.sz_valid)
    else $error("Bitmap accessed before the slot size was known.");

endmodule

// ----- verif/tb_bitmap_slab_allocator_unit.sv -----
// Self-checking testbench for the bitmap slab allocator unit with a scoreboard and random idling.
module tb_bitmap_slab_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam int SLOTS = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [5:0]  idx;
  } slab_result_t;

  class slab_scoreboard;
    logic [15:0]  size_reg  = 16'd4;
    logic [8:0]   align_reg = 9'd4;
    logic [6:0]   count_reg = 7'd64;
    logic [31:0]  base_reg  = 32'd0;
    bit           used[SLOTS];
    slab_result_t pending[$];
    int           errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [31:0] value);
      case (index)
        CFG_ITEM_SIZE:  size_reg  = value[15:0];
        CFG_ITEM_ALIGN: align_reg = value[8:0];
        CFG_ITEM_COUNT: count_reg = value[6:0];
        CFG_DATA_BASE:  base_reg  = value;
        default: ;
      endcase
    endfunction

    function logic [31:0] slot_bytes();
      logic [31:0] a, s;
      a = (align_reg == '0) ? 32'd1 : 32'(align_reg);
      s = (size_reg == '0) ? 32'd1 : 32'(size_reg);
      return ((s + a - 32'd1) / a) * a;
    endfunction

    function int active_count();
      return (count_reg > SLOTS) ? SLOTS : int'(count_reg);
    endfunction

    function void note_request(logic [1:0] req, logic [31:0] addr, logic [5:0] sidx);
      slab_result_t r;
      logic [31:0]  sz, off, q;
      int           n;
      r = '0;
      n = active_count();
      sz = slot_bytes();
      case (req)
        REQ_ALLOC: begin
          r.status = ST_NONE;
          for (int i = 0; i < n && r.status != ST_OK; i++) begin
            if (!used[i]) begin
              used[i] = 1'b1;
              r.status = ST_OK;
              r.addr = base_reg + sz * i;
              r.idx = i[5:0];
            end
          end
        end
        REQ_FREE: begin
          off = addr - base_reg;
          q = off / sz;
          if ((off % sz) != 0 || q >= n || !used[q]) begin
            r.status = ST_INVALID;
          end else begin
            used[q] = 1'b0;
            r.status = ST_OK;
            r.addr = addr;
            r.idx = q[5:0];
          end
        end
        REQ_GET: begin
          if (sidx >= n || !used[sidx]) begin
            r.status = ST_NONE;
          end else begin
            r.status = ST_OK;
            r.addr = base_reg + sz * sidx;
            r.idx = sidx;
          end
        end
        default: r.status = ST_INVALID;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] addr, logic [5:0] idx);
      slab_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result: status %0d address %h index %0d", status, addr, idx);
        return;
      end
      exp_r = pending.pop_front();
      if (status !== exp_r.status || addr !== exp_r.addr || idx !== exp_r.idx) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected status %0d address %h index %0d, got %0d %h %0d",
                   exp_r.status, exp_r.addr, exp_r.idx, status, addr, idx);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ITEM_SIZE;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_ALLOC;
  logic [31:0] in_address = '0;
  logic [5:0]  in_slot_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_slot_address;
  logic [5:0]  out_granted_index;

  slab_scoreboard sb;
  int idle_mode = 1;
  int stall_left = 0;

  bitmap_slab_allocator_unit #(.MAX_SLOTS(SLOTS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_address(in_address),
    .in_slot_index(in_slot_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_slot_address(out_slot_address),
    .out_granted_index(out_granted_index)
  );

  always #6 clk = ~clk;

  function automatic int gap_len();
    int r;
    if (idle_mode == 0) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 15 || idle_mode == 1) return $urandom_range(1, 3);
    return $urandom_range(16, 64);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_slot_address, out_granted_index);
  end

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(index, value);
  endtask

  task automatic write_config(logic [31:0] size_v, logic [31:0] align_v,
                              logic [31:0] count_v, logic [31:0] base_v);
    write_reg(CFG_ITEM_SIZE, size_v);
    write_reg(CFG_ITEM_ALIGN, align_v);
    write_reg(CFG_ITEM_COUNT, count_v);
    write_reg(CFG_DATA_BASE, base_v);
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(logic [1:0] req, logic [31:0] addr, logic [5:0] sidx);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_address <= addr;
    in_slot_index <= sidx;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, addr, sidx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    logic [1:0]  req;
    logic [31:0] addr, sz;
    logic [5:0]  sidx;
    int          pick, n, k;
    int          busy[$];
    req = REQ_ALLOC;
    addr = $urandom;
    sidx = $urandom_range(0, 63);
    n = sb.active_count();
    sz = sb.slot_bytes();
    for (int i = 0; i < n; i++)
      if (sb.used[i]) busy.push_back(i);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      req = REQ_ALLOC;
    end else if (pick < 65) begin
      req = REQ_FREE;
      if (busy.size() > 0) begin
        k = busy[$urandom_range(0, busy.size() - 1)];
        addr = sb.base_reg + sz * k;
      end
    end else if (pick < 80) begin
      req = REQ_GET;
      if (busy.size() > 0 && $urandom_range(0, 3) != 0)
        sidx = busy[$urandom_range(0, busy.size() - 1)];
    end else if (pick < 92) begin
      req = REQ_FREE;
      case ($urandom_range(0, 3))
        0: ;
        1: addr = sb.base_reg + sz * $urandom_range(0, 63) + $urandom_range(1, 3);
        2: addr = sb.base_reg + sz * n;
        default: addr = sb.base_reg + sz * $urandom_range(0, 63);
      endcase
    end else if (pick < 96) begin
      req = REQ_BAD;
    end else begin
      req = REQ_GET;
    end
    send_request(req, addr, sidx);
  endtask

  initial begin
    int          sent;
    int          items;
    logic [31:0] c_size, c_align, c_count, c_base;
    sent = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: basic allocation, lookups and the ways a free can be refused.
    send_request(REQ_ALLOC, 32'h0, 6'd0);
    send_request(REQ_ALLOC, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_ALLOC, 32'h0, 6'd0);
    send_request(REQ_GET, 32'h0, 6'd1);
    send_request(REQ_GET, 32'h0, 6'd63);
    send_request(REQ_FREE, 32'd4, 6'd0);
    send_request(REQ_FREE, 32'd4, 6'd0);
    send_request(REQ_FREE, 32'd9, 6'd0);
    send_request(REQ_FREE, 32'hFFFF_FFFC, 6'd0);
    send_request(REQ_BAD, 32'hFFFF_FFFF, 6'd63);
    send_request(REQ_ALLOC, 32'h0, 6'd0);
    send_request(REQ_GET, 32'h0, 6'd0);
    drain();

    // Zero size, zero alignment and an empty pool.
    write_config(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_ALLOC, 32'h0, 6'd0);
    send_request(REQ_FREE, 32'hFFFF_FFFF, 6'd0);
    send_request(REQ_GET, 32'h0, 6'd0);
    drain();

    // Largest size, oversized alignment and a count beyond the maximum, with address wrap.
    write_config(32'd65535, 32'd511, 32'd127, 32'hFFFF_0000);
    send_request(REQ_ALLOC, 32'h0, 6'd0);
    send_request(REQ_GET, 32'h0, 6'd63);
    send_request(REQ_FREE, 32'hFFFF_0000, 6'd0);
    drain();

    // A shrunk pool that fills up while slots above the count stay in use.
    write_config(32'd1, 32'd256, 32'd2, 32'd0);
    send_request(REQ_ALLOC, 32'h0, 6'd0);
    send_request(REQ_ALLOC, 32'h0, 6'd0);
    send_request(REQ_GET, 32'h0, 6'd2);
    send_request(REQ_FREE, 32'd512, 6'd0);
    send_request(REQ_FREE, 32'd256, 6'd0);
    drain();

    while (sent < 2000) begin
      case ($urandom_range(0, 7))
        0: c_size = 32'd0;
        1: c_size = 32'd65535;
        2: c_size = 32'd1;
        3: c_size = $urandom_range(0, 65535);
        default: c_size = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 7))
        0: c_align = 32'd0;
        1: c_align = 32'd1;
        2: c_align = 32'd256;
        3: c_align = 32'd511;
        4: c_align = $urandom_range(0, 511);
        default: c_align = 32'd1 << $urandom_range(0, 4);
      endcase
      case ($urandom_range(0, 9))
        0: c_count = 32'd0;
        1: c_count = 32'd1;
        2, 3: c_count = 32'd64;
        4: c_count = $urandom_range(65, 127);
        5, 6: c_count = $urandom_range(1, 64);
        default: c_count = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 4))
        0: c_base = 32'd0;
        1: c_base = 32'hFFFF_FFFF;
        2: c_base = 32'hFFFF_FF00 | $urandom_range(0, 255);
        default: c_base = $urandom;
      endcase
      write_config(c_size, c_align, c_count, c_base);
      idle_mode = $urandom_range(0, 2);
      items = $urandom_range(60, 200);
      repeat (items) random_request();
      sent += items;
      drain();
    end

    idle_mode = 0;
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
